// ----- rtl/rhc_pkg.sv -----
// Shared types and constants for the RGB to HSV converter pipeline.
package rhc_pkg;

    localparam int unsigned COMP_W   = 8;
    localparam int unsigned PIXEL_W  = 3 * COMP_W;
    localparam int unsigned HUE_W    = 9;
    localparam int unsigned SAT_W    = 16;
    localparam int unsigned DEN_W    = COMP_W + 1;
    localparam int unsigned HUE_Q_W  = 7;
    localparam int unsigned N_CELLS  = SAT_W;

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    localparam logic [HUE_W-1:0] BASE_RED   = HUE_W'(300);
    localparam logic [HUE_W-1:0] BASE_GREEN = HUE_W'(60);
    localparam logic [HUE_W-1:0] BASE_BLUE  = HUE_W'(180);
    localparam logic [HUE_W-1:0] HUE_WRAP   = HUE_W'(360);

    typedef struct packed {
        logic [COMP_W-1:0] sat_rem;
        logic [SAT_W-1:0]  sat_dvd;
        logic [DEN_W-1:0]  hue_rem;
        logic [SAT_W-1:0]  hue_dvd;
        logic [DEN_W-1:0]  den;
        logic [COMP_W-1:0] mx;
        logic [1:0]        sector;
        logic              grey;
        logic              black;
    } rhc_word_t;

endpackage

// ----- rtl/rgb_to_hsv_converter_core.sv -----
// RGB to HSV converter: prep stage, chain of division cells, output stage.
// Registers from input accept to output valid: 1 prep, 16 cells, 1 output register.
// Throughput: one pixel word per cycle unless out_ready stalls the chain; each cell handles one quotient bit.
// Any stage with a free register accepts a word, so stalls squeeze bubbles out.
// Reset: rst_n asynchronous, active low, clears all valid flags; no other state.
module rgb_to_hsv_converter_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [rhc_pkg::PIXEL_W-1:0] pixel_in,
    input  logic                       in_valid,
    output logic                       in_ready,
    output logic [rhc_pkg::HUE_W-1:0]   hue_deg,
    output logic [rhc_pkg::SAT_W-1:0]   saturation_frac,
    output logic [rhc_pkg::COMP_W-1:0]  value_level,
    output logic                       out_valid,
    input  logic                       out_ready
);
    import rhc_pkg::*;

    rhc_word_t chain_word  [0:N_CELLS];
    logic      chain_valid [0:N_CELLS];
    logic      chain_ready [0:N_CELLS];

    rhc_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_in (pixel_in),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .dn_word  (chain_word[0]),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0])
    );

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        rhc_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_word  (chain_word[i]),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .dn_word  (chain_word[i+1]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1])
        );
    end

    rhc_post u_post (
        .clk             (clk),
        .rst_n           (rst_n),
        .up_word         (chain_word[N_CELLS]),
        .up_valid        (chain_valid[N_CELLS]),
        .up_ready        (chain_ready[N_CELLS]),
        .hue_deg         (hue_deg),
        .saturation_frac (saturation_frac),
        .value_level     (value_level),
        .dn_valid        (out_valid),
        .dn_ready        (out_ready)
    );

endmodule

// ----- rtl/rhc_prep.sv -----
// Input stage: unpack the pixel, find max, min, sector and set up both dividends.
module rhc_prep (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [rhc_pkg::PIXEL_W-1:0] pixel_in,
    input  logic                       up_valid,
    output logic                       up_ready,
    output rhc_pkg::rhc_word_t         dn_word,
    output logic                       dn_valid,
    input  logic                       dn_ready
);
    import rhc_pkg::*;

    logic [COMP_W-1:0]   r;
    logic [COMP_W-1:0]   g;
    logic [COMP_W-1:0]   b;
    logic [COMP_W-1:0]   mx;
    logic [COMP_W-1:0]   mn;
    logic [COMP_W-1:0]   delta;
    logic [1:0]          sector;
    logic signed [DEN_W-1:0] diff;
    logic signed [17:0]  diff_ext;
    logic signed [17:0]  delta_ext;
    logic signed [17:0]  t_full;
    logic [PIXEL_W-1:0]  sat_dividend;
    rhc_word_t           word_next;
    rhc_word_t           word_reg;
    logic                valid_reg;

    assign r = pixel_in[23:16];
    assign g = pixel_in[15:8];
    assign b = pixel_in[7:0];

    always_comb
    begin
        if (r >= g && r >= b)
        begin
            sector = SEC_RED;
            mx     = r;
            diff   = $signed({1'b0, g}) - $signed({1'b0, b});
        end
        else if (g >= b)
        begin
            sector = SEC_GREEN;
            mx     = g;
            diff   = $signed({1'b0, b}) - $signed({1'b0, r});
        end
        else
        begin
            sector = SEC_BLUE;
            mx     = b;
            diff   = $signed({1'b0, r}) - $signed({1'b0, g});
        end
        if (r <= g && r <= b)
            mn = r;
        else if (g <= b)
            mn = g;
        else
            mn = b;
    end

    assign delta        = mx - mn;
    assign diff_ext     = {{(18-DEN_W){diff[DEN_W-1]}}, diff};
    assign delta_ext    = $signed({10'd0, delta});
    assign t_full       = diff_ext * 18'sd120 + delta_ext * 18'sd121;
    assign sat_dividend = {delta, 16'd0} - {16'd0, delta};

    always_comb
    begin
        word_next.sat_rem = sat_dividend[PIXEL_W-1:SAT_W];
        word_next.sat_dvd = sat_dividend[SAT_W-1:0];
        word_next.hue_rem = '0;
        word_next.hue_dvd = t_full[SAT_W-1:0];
        word_next.den     = {delta, 1'b0};
        word_next.mx      = mx;
        word_next.sector  = sector;
        word_next.grey    = (delta == '0);
        word_next.black   = (mx == '0);
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            word_reg <= word_next;
    end

    assign dn_word  = word_reg;
    assign dn_valid = valid_reg;

endmodule

// ----- rtl/rhc_div_cell.sv -----
// One restoring-division cell: one quotient bit of saturation and of hue.
module rhc_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  rhc_pkg::rhc_word_t up_word,
    input  logic               up_valid,
    output logic               up_ready,
    output rhc_pkg::rhc_word_t dn_word,
    output logic               dn_valid,
    input  logic               dn_ready
);
    import rhc_pkg::*;

    logic [COMP_W:0]  sat_trial;
    logic [DEN_W:0]   hue_trial;
    logic             sat_bit;
    logic             hue_bit;
    logic [COMP_W:0]  sat_diff;
    logic [DEN_W:0]   hue_diff;
    rhc_word_t        word_next;
    rhc_word_t        word_reg;
    logic             valid_reg;

    assign sat_trial = {up_word.sat_rem, up_word.sat_dvd[SAT_W-1]};
    assign hue_trial = {up_word.hue_rem, up_word.hue_dvd[SAT_W-1]};
    assign sat_bit   = (sat_trial >= {1'b0, up_word.mx});
    assign hue_bit   = (hue_trial >= {1'b0, up_word.den});
    assign sat_diff  = sat_trial - {1'b0, up_word.mx};
    assign hue_diff  = hue_trial - {1'b0, up_word.den};

    always_comb
    begin
        word_next         = up_word;
        word_next.sat_rem = sat_bit ? sat_diff[COMP_W-1:0] : sat_trial[COMP_W-1:0];
        word_next.sat_dvd = {up_word.sat_dvd[SAT_W-2:0], sat_bit};
        word_next.hue_rem = hue_bit ? hue_diff[DEN_W-1:0] : hue_trial[DEN_W-1:0];
        word_next.hue_dvd = {up_word.hue_dvd[SAT_W-2:0], hue_bit};
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            word_reg <= word_next;
    end

    assign dn_word  = word_reg;
    assign dn_valid = valid_reg;

endmodule

// ----- rtl/rhc_post.sv -----
// Output stage: add the sector offset, wrap hue, apply grey and black cases.
module rhc_post (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rhc_pkg::rhc_word_t        up_word,
    input  logic                      up_valid,
    output logic                      up_ready,
    output logic [rhc_pkg::HUE_W-1:0]  hue_deg,
    output logic [rhc_pkg::SAT_W-1:0]  saturation_frac,
    output logic [rhc_pkg::COMP_W-1:0] value_level,
    output logic                      dn_valid,
    input  logic                      dn_ready
);
    import rhc_pkg::*;

    logic [HUE_W-1:0]  base;
    logic [HUE_W-1:0]  hue_sum;
    logic [HUE_W-1:0]  hue_next;
    logic [SAT_W-1:0]  sat_next;
    logic [HUE_W-1:0]  hue_reg;
    logic [SAT_W-1:0]  sat_reg;
    logic [COMP_W-1:0] val_reg;
    logic              valid_reg;

    always_comb
    begin
        unique case (up_word.sector)
            SEC_RED:   base = BASE_RED;
            SEC_GREEN: base = BASE_GREEN;
            SEC_BLUE:  base = BASE_BLUE;
            default:   base = BASE_BLUE;
        endcase
    end

    assign hue_sum = {2'b00, up_word.hue_dvd[HUE_Q_W-1:0]} + base;

    always_comb
    begin
        if (up_word.grey)
            hue_next = '0;
        else if (hue_sum >= HUE_WRAP)
            hue_next = hue_sum - HUE_WRAP;
        else
            hue_next = hue_sum;
        sat_next = up_word.black ? '0 : up_word.sat_dvd;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= up_word.mx;
        end
    end

    assign hue_deg         = hue_reg;
    assign saturation_frac = sat_reg;
    assign value_level     = val_reg;
    assign dn_valid        = valid_reg;

endmodule

// ----- tb/rgb_to_hsv_converter_core_tb.sv -----
// Self-checking testbench for the RGB to HSV converter core with a built-in HSV predictor.
module rgb_to_hsv_converter_core_tb;

    import rhc_pkg::*;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  sat;
        logic [COMP_W-1:0] val;
    } hsv_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] px;
        logic               typed;
        hsv_t               hsv;
    } pixel_row_t;

    localparam int N_ROWS = 24;
    localparam int N_RANDOM = 1330;

    localparam pixel_row_t PIXEL_ROWS [0:N_ROWS-1] = '{
        '{24'h000000, 1'b1, '{9'd0,   16'd0,     8'd0}},
        '{24'hFFFFFF, 1'b1, '{9'd0,   16'd0,     8'd255}},
        '{24'h808080, 1'b1, '{9'd0,   16'd0,     8'd128}},
        '{24'h010101, 1'b1, '{9'd0,   16'd0,     8'd1}},
        '{24'hFF0000, 1'b1, '{9'd0,   16'd65535, 8'd255}},
        '{24'h00FF00, 1'b1, '{9'd120, 16'd65535, 8'd255}},
        '{24'h0000FF, 1'b1, '{9'd240, 16'd65535, 8'd255}},
        '{24'hFFFF00, 1'b1, '{9'd60,  16'd65535, 8'd255}},
        '{24'h00FFFF, 1'b1, '{9'd180, 16'd65535, 8'd255}},
        '{24'hFF00FF, 1'b1, '{9'd300, 16'd65535, 8'd255}},
        '{24'h010000, 1'b1, '{9'd0,   16'd65535, 8'd1}},
        '{24'h000001, 1'b1, '{9'd240, 16'd65535, 8'd1}},
        '{24'hFF0001, 1'b0, '0},
        '{24'hFF0100, 1'b0, '0},
        '{24'h01FF00, 1'b0, '0},
        '{24'hFE01FF, 1'b0, '0},
        '{24'h7F8081, 1'b0, '0},
        '{24'h123456, 1'b0, '0},
        '{24'hABCDEF, 1'b0, '0},
        '{24'hFFFE00, 1'b0, '0},
        '{24'h00FEFF, 1'b0, '0},
        '{24'hC0C0FF, 1'b0, '0},
        '{24'hFF7F00, 1'b0, '0},
        '{24'h800000, 1'b0, '0}
    };

    logic                clk;
    logic                rst_n;
    logic [PIXEL_W-1:0]  pixel_in;
    logic                in_valid;
    logic                in_ready;
    logic [HUE_W-1:0]    hue_deg;
    logic [SAT_W-1:0]    saturation_frac;
    logic [COMP_W-1:0]   value_level;
    logic                out_valid;
    logic                out_ready;

    hsv_t hsv_due_q [$];
    int   mismatch_count;
    int   pixels_sent;
    int   results_seen;
    bit   lull;

    rgb_to_hsv_converter_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixel_in        (pixel_in),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .hue_deg         (hue_deg),
        .saturation_frac (saturation_frac),
        .value_level     (value_level),
        .out_valid       (out_valid),
        .out_ready       (out_ready)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic hsv_t hsv_of_pixel(input logic [PIXEL_W-1:0] px);
        hsv_t res;
        int r;
        int g;
        int b;
        int mx;
        int mn;
        int span;
        int diff;
        int base;
        int num;
        r = px[23:16];
        g = px[15:8];
        b = px[7:0];
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        span = mx - mn;
        if (span == 0)
            res.hue = '0;
        else
        begin
            if (mx == r)
            begin
                diff = g - b;
                base = 360;
            end
            else if (mx == g)
            begin
                diff = b - r;
                base = 120;
            end
            else
            begin
                diff = r - g;
                base = 240;
            end
            num = 120 * diff + (2 * base + 1) * span;
            res.hue = HUE_W'((num / (2 * span)) % 360);
        end
        res.sat = (mx == 0) ? '0 : SAT_W'((span * 65535) / mx);
        res.val = COMP_W'(mx);
        return res;
    endfunction

    function automatic logic [PIXEL_W-1:0] random_pixel();
        logic [COMP_W-1:0] c [3];
        logic [COMP_W-1:0] m;
        logic [COMP_W-1:0] o;
        int mode;
        int k;
        mode = $urandom_range(0, 9);
        for (k = 0; k < 3; k++)
            c[k] = COMP_W'($urandom);
        m = COMP_W'($urandom_range(1, 255));
        o = COMP_W'($urandom_range(0, m - 1));
        case (mode)
            5: c = '{m, m, m};
            6:
            begin
                k = $urandom_range(0, 2);
                c = '{m, m, m};
                c[k] = o;
            end
            7:
                for (k = 0; k < 3; k++)
                    case ($urandom_range(0, 2))
                        0: c[k] = '0;
                        1: c[k] = '1;
                        default: ;
                    endcase
            8:
                for (k = 0; k < 3; k++)
                    c[k] = COMP_W'($urandom_range(0, 3));
            9:
            begin
                k = $urandom_range(0, 2);
                c = '{m - COMP_W'($urandom_range(0, 1)), m - COMP_W'($urandom_range(0, 1)),
                      m - COMP_W'($urandom_range(0, 1))};
                c[k] = m;
            end
            default: ;
        endcase
        return {c[0], c[1], c[2]};
    endfunction

    task automatic drive_pixel(input logic [PIXEL_W-1:0] px, input hsv_t due);
        int gap;
        pixel_in <= px;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        hsv_due_q.push_back(due);
        pixels_sent++;
        gap = lull ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receive side: hold ready low for a drawn number of cycles after each word
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                stall = lull ? 0 : $urandom_range(0, 4);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        hsv_t due;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (hsv_due_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected word hue=%0d sat=%0d val=%0d", $time,
                         hue_deg, saturation_frac, value_level);
            end
            else
            begin
                due = hsv_due_q.pop_front();
                if (hue_deg !== due.hue)
                begin
                    mismatch_count++;
                    $display("%0t: hue_deg expected %0d actual %0d", $time, due.hue, hue_deg);
                end
                if (saturation_frac !== due.sat)
                begin
                    mismatch_count++;
                    $display("%0t: saturation_frac expected %0d actual %0d", $time,
                             due.sat, saturation_frac);
                end
                if (value_level !== due.val)
                begin
                    mismatch_count++;
                    $display("%0t: value_level expected %0d actual %0d", $time,
                             due.val, value_level);
                end
            end
        end
    end

    initial
    begin
        logic [PIXEL_W-1:0] px;
        int i;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel_in = '0;
        lull = 1'b0;
        mismatch_count = 0;
        pixels_sent = 0;
        results_seen = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i < N_ROWS; i++)
            drive_pixel(PIXEL_ROWS[i].px, PIXEL_ROWS[i].typed ? PIXEL_ROWS[i].hsv
                                                              : hsv_of_pixel(PIXEL_ROWS[i].px));
        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i % 150 == 0)
                lull = ($urandom_range(0, 3) == 0);
            px = random_pixel();
            drive_pixel(px, hsv_of_pixel(px));
        end
        in_valid <= 1'b0;
        lull = 1'b0;
        while (hsv_due_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Drove %0d pixels (%0d table rows, rest random with ties, greys, extremes)",
                 pixels_sent, N_ROWS);
        $display("Compared %0d HSV words, %0d field mismatches", results_seen, mismatch_count);
        if (mismatch_count == 0 && hsv_due_q.size() == 0)
            $display("[rgb_to_hsv_converter_core] OK");
        else
            $display("[rgb_to_hsv_converter_core] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d words still due", hsv_due_q.size());
        $display("[rgb_to_hsv_converter_core] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rhc_pkg.sv
rtl/rhc_prep.sv
rtl/rhc_div_cell.sv
rtl/rhc_post.sv
rtl/rgb_to_hsv_converter_core.sv
tb/rgb_to_hsv_converter_core_tb.sv
